FILE: hdl/rpp_pkg.sv
package rpp_pkg;

    // Angle formats: degrees Q8 at the input side, degrees Q20 in the rotator
    localparam int ANGLE_WIDTH     = 18;
    localparam int TURN_W          = 19;
    localparam int ANG_W           = 30;
    localparam int ANG_Q20_SHIFT   = 12;
    localparam int DEG_HALF_TURN   = 180;
    localparam int DEG_Q8_ONE      = 256;
    localparam int HALF_TURN_Q8    = DEG_HALF_TURN * DEG_Q8_ONE;
    localparam int FULL_TURN_Q8    = 2 * HALF_TURN_Q8;
    localparam int QUARTER_TURN_Q8 = HALF_TURN_Q8 / 2;

    // Rotator gain compensation, Q24
    localparam int GAIN_W        = 25;
    localparam int GAIN_SHIFT    = 24;
    localparam int GAIN_INF_Q24  = 10188014;
    localparam int GAIN_CORR_Q24 = 6792009;
    localparam int TABLE_LEN     = 24;

    // Extra bits over the coordinate width: sign of the difference, Q24 gain, headroom
    localparam int XW_EXTRA = 27;

    typedef logic signed [TURN_W-1:0] turn_t;
    typedef logic signed [ANG_W-1:0]  angle_t;
    typedef logic signed [GAIN_W-1:0] gain_t;

    // atan(2^-i) in degrees, Q20, rounded to nearest
    function automatic angle_t atan_q20(input int idx);
        angle_t val;
        case (idx)
            0:       val = angle_t'(47185920);
            1:       val = angle_t'(27855475);
            2:       val = angle_t'(14718068);
            3:       val = angle_t'(7471121);
            4:       val = angle_t'(3750058);
            5:       val = angle_t'(1876857);
            6:       val = angle_t'(938658);
            7:       val = angle_t'(469357);
            8:       val = angle_t'(234682);
            9:       val = angle_t'(117342);
            10:      val = angle_t'(58671);
            11:      val = angle_t'(29335);
            12:      val = angle_t'(14668);
            13:      val = angle_t'(7334);
            14:      val = angle_t'(3667);
            15:      val = angle_t'(1833);
            16:      val = angle_t'(917);
            17:      val = angle_t'(458);
            18:      val = angle_t'(229);
            19:      val = angle_t'(115);
            20:      val = angle_t'(57);
            21:      val = angle_t'(29);
            22:      val = angle_t'(14);
            23:      val = angle_t'(7);
            default: val = '0;
        endcase
        return val;
    endfunction

    // Inverse rotator gain for a given number of micro-rotations, Q24
    function automatic gain_t gain_q24(input int steps);
        longint g;
        g = longint'(GAIN_INF_Q24) + (longint'(GAIN_CORR_Q24) >>> (2 * steps));
        return g[GAIN_W-1:0];
    endfunction

endpackage

FILE: hdl/rpp_prep.sv
module rpp_prep #(
    parameter int COORD_WIDTH    = 24,
    parameter int ROTATION_STEPS = 16,
    parameter int XW             = COORD_WIDTH + 27
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [COORD_WIDTH-1:0]          point_x,
    input  logic signed [COORD_WIDTH-1:0]          point_y,
    input  logic signed [COORD_WIDTH-1:0]          pivot_x,
    input  logic signed [COORD_WIDTH-1:0]          pivot_y,
    input  logic signed [rpp_pkg::ANGLE_WIDTH-1:0] angle_deg,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [XW-1:0]                   out_x,
    output logic signed [XW-1:0]                   out_y,
    output rpp_pkg::angle_t                        out_t,
    output logic signed [COORD_WIDTH-1:0]          out_cx,
    output logic signed [COORD_WIDTH-1:0]          out_cy
);
    import rpp_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = DW + GAIN_W;
    localparam gain_t GAIN = gain_q24(ROTATION_STEPS);
    localparam turn_t HALF_S     = turn_t'(HALF_TURN_Q8);
    localparam turn_t NEG_HALF_S = turn_t'(-HALF_TURN_Q8);
    localparam turn_t FULL_S     = turn_t'(FULL_TURN_Q8);
    localparam turn_t QUART_S    = turn_t'(QUARTER_TURN_Q8);
    localparam turn_t NEG_QUART_S = turn_t'(-QUARTER_TURN_Q8);

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    // Stage 1: differences and angle reduction to one turn
    logic signed [DW-1:0] dx1_reg, dy1_reg, dx1_next, dy1_next;
    turn_t t1_reg, t1_next, neg_a;
    logic signed [COORD_WIDTH-1:0] cx1_reg, cy1_reg;

    // Stage 2: quarter-turn fold
    logic signed [DW-1:0] dx2_reg, dy2_reg, dx2_next, dy2_next;
    turn_t t2_reg, t2_next;
    logic signed [COORD_WIDTH-1:0] cx2_reg, cy2_reg;

    // Stage 3: gain pre-scale
    logic signed [PW-1:0] px_prod, py_prod;
    logic signed [XW-1:0] x3_reg, y3_reg;
    angle_t t3_reg, t3_next;
    logic signed [COORD_WIDTH-1:0] cx3_reg, cy3_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        dx1_next = {point_x[COORD_WIDTH-1], point_x} - {pivot_x[COORD_WIDTH-1], pivot_x};
        dy1_next = {point_y[COORD_WIDTH-1], point_y} - {pivot_y[COORD_WIDTH-1], pivot_y};
        neg_a = turn_t'(0) - {{(TURN_W-ANGLE_WIDTH){angle_deg[ANGLE_WIDTH-1]}}, angle_deg};
        if (neg_a >= HALF_S) begin
            t1_next = neg_a - FULL_S;
        end else if (neg_a < NEG_HALF_S) begin
            t1_next = neg_a + FULL_S;
        end else begin
            t1_next = neg_a;
        end
    end

    always_comb begin
        if (t1_reg > QUART_S) begin
            dx2_next = -dy1_reg;
            dy2_next = dx1_reg;
            t2_next  = t1_reg - QUART_S;
        end else if (t1_reg < NEG_QUART_S) begin
            dx2_next = dy1_reg;
            dy2_next = -dx1_reg;
            t2_next  = t1_reg + QUART_S;
        end else begin
            dx2_next = dx1_reg;
            dy2_next = dy1_reg;
            t2_next  = t1_reg;
        end
    end

    assign px_prod = dx2_reg * GAIN;
    assign py_prod = dy2_reg * GAIN;
    assign t3_next = angle_t'(t2_reg) <<< ANG_Q20_SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
            t1_reg  <= t1_next;
            cx1_reg <= pivot_x;
            cy1_reg <= pivot_y;
        end
        if (en2) begin
            dx2_reg <= dx2_next;
            dy2_reg <= dy2_next;
            t2_reg  <= t2_next;
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
        end
        if (en3) begin
            x3_reg  <= XW'(px_prod);
            y3_reg  <= XW'(py_prod);
            t3_reg  <= t3_next;
            cx3_reg <= cx2_reg;
            cy3_reg <= cy2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_x     = x3_reg;
    assign out_y     = y3_reg;
    assign out_t     = t3_reg;
    assign out_cx    = cx3_reg;
    assign out_cy    = cy3_reg;

`ifndef NO_ASSERTIONS
    a_reduced_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (t1_reg >= NEG_HALF_S) && (t1_reg < HALF_S))
        else $error("reduced angle outside half turn");

    a_folded_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (t2_reg >= NEG_QUART_S) && (t2_reg <= QUART_S))
        else $error("folded angle outside quarter turn");

    a_stage3_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !out_ready |=> v3_reg && $stable(t3_reg) && $stable(x3_reg))
        else $error("stalled prescale stage changed");
`endif

endmodule

FILE: hdl/rpp_cordic_stage.sv
module rpp_cordic_stage #(
    parameter int COORD_WIDTH = 24,
    parameter int XW          = COORD_WIDTH + 27,
    parameter int STAGE       = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [XW-1:0]          in_x,
    input  logic signed [XW-1:0]          in_y,
    input  rpp_pkg::angle_t               in_t,
    input  logic signed [COORD_WIDTH-1:0] in_cx,
    input  logic signed [COORD_WIDTH-1:0] in_cy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [XW-1:0]          out_x,
    output logic signed [XW-1:0]          out_y,
    output rpp_pkg::angle_t               out_t,
    output logic signed [COORD_WIDTH-1:0] out_cx,
    output logic signed [COORD_WIDTH-1:0] out_cy
);
    import rpp_pkg::*;

    localparam angle_t ATAN = atan_q20(STAGE);

    logic                 en;
    logic                 v_reg;
    logic signed [XW-1:0] xs, ys, x_next, y_next, x_reg, y_reg;
    angle_t               t_next, t_reg;
    logic signed [COORD_WIDTH-1:0] cx_reg, cy_reg;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    // One micro-rotation; direction follows the sign of the residual angle
    always_comb begin
        xs = in_x >>> STAGE;
        ys = in_y >>> STAGE;
        if (!in_t[ANG_W-1]) begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            t_next = in_t - ATAN;
        end else begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            t_next = in_t + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            t_reg  <= t_next;
            cx_reg <= in_cx;
            cy_reg <= in_cy;
        end
    end

    assign out_valid = v_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_t     = t_reg;
    assign out_cx    = cx_reg;
    assign out_cy    = cy_reg;

endmodule

FILE: hdl/rpp_post.sv
module rpp_post #(
    parameter int COORD_WIDTH = 24,
    parameter int XW          = COORD_WIDTH + 27
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [XW-1:0]          in_x,
    input  logic signed [XW-1:0]          in_y,
    input  logic signed [COORD_WIDTH-1:0] in_cx,
    input  logic signed [COORD_WIDTH-1:0] in_cy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y
);
    import rpp_pkg::*;

    localparam int RW = XW - GAIN_SHIFT;
    localparam int SW = RW + 1;
    localparam logic signed [XW-1:0] HALF_LSB = XW'(1) <<< (GAIN_SHIFT - 1);
    localparam logic signed [COORD_WIDTH-1:0] SAT_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] SAT_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic en1, en2;
    logic v1_reg, v2_reg;
    logic signed [XW-1:0] xa, ya;
    logic signed [RW-1:0] xr_reg, yr_reg;
    logic signed [COORD_WIDTH-1:0] cx1_reg, cy1_reg;
    logic signed [SW-1:0] sx, sy;
    logic signed [COORD_WIDTH-1:0] ox_next, oy_next, ox_reg, oy_reg;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Round half up out of Q24
    assign xa = in_x + HALF_LSB;
    assign ya = in_y + HALF_LSB;

    // Add the pivot back and clamp to the coordinate range
    assign sx = SW'(cx1_reg) + SW'(xr_reg);
    assign sy = SW'(cy1_reg) + SW'(yr_reg);

    always_comb begin
        if (sx[SW-1:COORD_WIDTH-1] == {(SW-COORD_WIDTH+1){sx[SW-1]}}) begin
            ox_next = sx[COORD_WIDTH-1:0];
        end else begin
            ox_next = sx[SW-1] ? SAT_LO : SAT_HI;
        end
        if (sy[SW-1:COORD_WIDTH-1] == {(SW-COORD_WIDTH+1){sy[SW-1]}}) begin
            oy_next = sy[COORD_WIDTH-1:0];
        end else begin
            oy_next = sy[SW-1] ? SAT_LO : SAT_HI;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            xr_reg  <= xa[XW-1:GAIN_SHIFT];
            yr_reg  <= ya[XW-1:GAIN_SHIFT];
            cx1_reg <= in_cx;
            cy1_reg <= in_cy;
        end
        if (en2) begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;

endmodule

FILE: hdl/rotate_point_about_pivot_unit.sv
// Channel   Dir  tdata fields (low bit up)                              Item
// s_axis    in   point_x, point_y, pivot_x, pivot_y, angle_deg          one point
// m_axis    out  rotated_x, rotated_y                                   one result
//
// One result per input transfer. A new point is taken every cycle unless m_axis
// backpressure has filled the stages. The path runs through three preparation stages,
// one stage per CORDIC micro-rotation, then rounding and the pivot add/clamp.
// aresetn is synchronous, active low, and clears only the stage valid bits.
// Backpressure on m_axis stalls only the occupied stages; empty stages keep
// filling, so no transfer is lost or repeated.
module rotate_point_about_pivot_unit #(
    parameter int COORD_WIDTH    = 24,
    parameter int ROTATION_STEPS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // point_x, point_y, pivot_x, pivot_y (COORD_WIDTH each), angle_deg (18), zero pad
    input  logic [((4*COORD_WIDTH+rpp_pkg::ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // rotated_x, rotated_y (COORD_WIDTH each), zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
    import rpp_pkg::*;

    localparam int XW  = COORD_WIDTH + XW_EXTRA;
    localparam int M_W = ((2*COORD_WIDTH+7)/8)*8;
    localparam int N   = ROTATION_STEPS;

    logic signed [COORD_WIDTH-1:0] point_x, point_y, pivot_x, pivot_y;
    logic signed [ANGLE_WIDTH-1:0] angle_deg;
    logic signed [COORD_WIDTH-1:0] rotated_x, rotated_y;

    // Rotator chain: index i is the input of micro-rotation i
    logic                          valid_pipe [0:N];
    logic                          ready_pipe [0:N];
    logic signed [XW-1:0]          x_pipe     [0:N];
    logic signed [XW-1:0]          y_pipe     [0:N];
    angle_t                        t_pipe     [0:N];
    logic signed [COORD_WIDTH-1:0] cx_pipe    [0:N];
    logic signed [COORD_WIDTH-1:0] cy_pipe    [0:N];

    // Unpack the input transfer
    assign point_x   = s_axis_tdata[COORD_WIDTH-1:0];
    assign point_y   = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign pivot_x   = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign pivot_y   = s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];
    assign angle_deg = s_axis_tdata[4*COORD_WIDTH+ANGLE_WIDTH-1:4*COORD_WIDTH];

    // Differences, angle reduction and fold, gain pre-scale
    rpp_prep #(
        .COORD_WIDTH   (COORD_WIDTH),
        .ROTATION_STEPS(ROTATION_STEPS),
        .XW            (XW)
    ) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .point_x  (point_x),
        .point_y  (point_y),
        .pivot_x  (pivot_x),
        .pivot_y  (pivot_y),
        .angle_deg(angle_deg),
        .out_valid(valid_pipe[0]),
        .out_ready(ready_pipe[0]),
        .out_x    (x_pipe[0]),
        .out_y    (y_pipe[0]),
        .out_t    (t_pipe[0]),
        .out_cx   (cx_pipe[0]),
        .out_cy   (cy_pipe[0])
    );

    // One registered micro-rotation per step
    for (genvar i = 0; i < N; i++) begin : g_cordic
        rpp_cordic_stage #(
            .COORD_WIDTH(COORD_WIDTH),
            .XW         (XW),
            .STAGE      (i)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (valid_pipe[i]),
            .in_ready (ready_pipe[i]),
            .in_x     (x_pipe[i]),
            .in_y     (y_pipe[i]),
            .in_t     (t_pipe[i]),
            .in_cx    (cx_pipe[i]),
            .in_cy    (cy_pipe[i]),
            .out_valid(valid_pipe[i+1]),
            .out_ready(ready_pipe[i+1]),
            .out_x    (x_pipe[i+1]),
            .out_y    (y_pipe[i+1]),
            .out_t    (t_pipe[i+1]),
            .out_cx   (cx_pipe[i+1]),
            .out_cy   (cy_pipe[i+1])
        );
    end

    // Round, add pivot, clamp; its last register is the output register
    rpp_post #(
        .COORD_WIDTH(COORD_WIDTH),
        .XW         (XW)
    ) u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (valid_pipe[N]),
        .in_ready (ready_pipe[N]),
        .in_x     (x_pipe[N]),
        .in_y     (y_pipe[N]),
        .in_cx    (cx_pipe[N]),
        .in_cy    (cy_pipe[N]),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_x    (rotated_x),
        .out_y    (rotated_y)
    );

    // Pack the result transfer, pad with zeros
    assign m_axis_tdata = M_W'({rotated_y, rotated_x});

`ifndef NO_ASSERTIONS
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    a_chain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_pipe[0] && !ready_pipe[0] |=> valid_pipe[0] && $stable(t_pipe[0])
            && $stable(x_pipe[0]) && $stable(y_pipe[0]))
        else $error("rotator entry changed while stalled");
`endif

endmodule

FILE: tb/tb_rotate_point_about_pivot_unit.sv
`timescale 1ns / 1ps

module tb_rotate_point_about_pivot_unit;
    import rpp_pkg::*;

    localparam int CW             = 24;
    localparam int STEPS          = 16;
    localparam int ANGLE_W        = rpp_pkg::ANGLE_WIDTH;
    localparam int S_W            = ((4*CW+ANGLE_W+7)/8)*8;
    localparam int M_W            = ((2*CW+7)/8)*8;
    localparam int RANDOM_POINTS  = 1000;
    localparam int MAX_IDLE       = 17;
    // pipeline depth plus margin; used for the drain window at the end
    localparam int DRAIN_CYCLES   = STEPS + 5 + 20;
    // no transfer on either side for this long means the block is hung
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic signed [CW-1:0]      point_x;
        logic signed [CW-1:0]      point_y;
        logic signed [CW-1:0]      pivot_x;
        logic signed [CW-1:0]      pivot_y;
        logic signed [ANGLE_W-1:0] angle_deg;
    } point_req_t;

    typedef struct {
        logic [CW-1:0] rot_x;
        logic [CW-1:0] rot_y;
    } rotated_t;

    // Holds expected rotated points in order and compares them with the outputs.
    class rotation_scoreboard;
        rotated_t expected_rotations[$];
        int       mismatches;
        int       points_noted;
        int       results_checked;
        int       pivot_hits;

        // atan(2^-i) in degrees, Q20
        longint atan_deg_q20[TABLE_LEN] = '{
            47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
            938658, 469357, 234682, 117342, 58671, 29335,
            14668, 7334, 3667, 1833, 917, 458,
            229, 115, 57, 29, 14, 7
        };

        function logic [CW-1:0] clamp_coord(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (CW-1)) - 1;
            lo = -hi - 1;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v[CW-1:0];
        endfunction

        // Rotate the point about the pivot by minus the angle, CORDIC style.
        function rotated_t rotate_about_pivot(point_req_t r);
            rotated_t res;
            longint   px, py, cx, cy, ang, dx, dy;
            longint   half, quarter, turn, gain, x, y, xs, ys, tmp;
            px = longint'($signed(r.point_x));
            py = longint'($signed(r.point_y));
            cx = longint'($signed(r.pivot_x));
            cy = longint'($signed(r.pivot_y));
            ang = longint'($signed(r.angle_deg));
            dx = px - cx;
            dy = py - cy;
            if (dx == 0 && dy == 0) begin
                res.rot_x = clamp_coord(cx);
                res.rot_y = clamp_coord(cy);
                return res;
            end
            half = longint'(DEG_HALF_TURN) <<< 20;
            quarter = half / 2;
            // negate and move to Q20, then reduce to [-180, 180)
            turn = -ang * (longint'(1) <<< ANG_Q20_SHIFT);
            while (turn >= half) turn -= 2 * half;
            while (turn < -half) turn += 2 * half;
            gain = longint'(GAIN_INF_Q24) + (longint'(GAIN_CORR_Q24) >>> (2 * STEPS));
            x = dx * gain;
            y = dy * gain;
            // fold into [-90, 90] with an exact quarter turn
            if (turn > quarter) begin
                tmp = x; x = -y; y = tmp;
                turn -= quarter;
            end else if (turn < -quarter) begin
                tmp = x; x = y; y = -tmp;
                turn += quarter;
            end
            for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (turn >= 0) begin
                    x -= ys; y += xs; turn -= atan_deg_q20[i];
                end else begin
                    x += ys; y -= xs; turn += atan_deg_q20[i];
                end
            end
            // round half up out of Q24, add the pivot back, clamp
            x = (x + (longint'(1) <<< (GAIN_SHIFT-1))) >>> GAIN_SHIFT;
            y = (y + (longint'(1) <<< (GAIN_SHIFT-1))) >>> GAIN_SHIFT;
            res.rot_x = clamp_coord(cx + x);
            res.rot_y = clamp_coord(cy + y);
            return res;
        endfunction

        function void note_point(point_req_t r);
            expected_rotations.push_back(rotate_about_pivot(r));
            points_noted++;
            if (r.point_x == r.pivot_x && r.point_y == r.pivot_y) pivot_hits++;
        endfunction

        function void check_rotated(logic [M_W-1:0] data);
            rotated_t exp_pt;
            logic [CW-1:0] act_x;
            logic [CW-1:0] act_y;
            act_x = data[CW-1:0];
            act_y = data[2*CW-1:CW];
            results_checked++;
            if (expected_rotations.size() == 0) begin
                $display("%0t unexpected result: expected none, actual x=%0d y=%0d",
                         $time, $signed(act_x), $signed(act_y));
                mismatches++;
                return;
            end
            exp_pt = expected_rotations.pop_front();
            if (act_x !== exp_pt.rot_x) begin
                $display("%0t rotated_x mismatch: expected %0d, actual %0d",
                         $time, $signed(exp_pt.rot_x), $signed(act_x));
                mismatches++;
            end
            if (act_y !== exp_pt.rot_y) begin
                $display("%0t rotated_y mismatch: expected %0d, actual %0d",
                         $time, $signed(exp_pt.rot_y), $signed(act_y));
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_rotations.size();
        endfunction
    endclass

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    // point_x, point_y, pivot_x, pivot_y, angle_deg, zero pad
    logic [S_W-1:0] s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    // rotated_x, rotated_y
    logic [M_W-1:0] m_axis_tdata;

    rotation_scoreboard sb = new();
    bit sender_burst = 1'b0;
    bit receiver_burst = 1'b0;
    int idle_cycles = 0;
    int directed_points = 0;

    rotate_point_about_pivot_unit #(
        .COORD_WIDTH   (CW),
        .ROTATION_STEPS(STEPS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Draw a per-item wait; burst mode runs back to back.
    function automatic int draw_wait(bit burst);
        return burst ? 0 : int'($urandom_range(0, MAX_IDLE));
    endfunction

    function automatic point_req_t make_point(int px, int py, int cx, int cy, int ang);
        point_req_t r;
        r.point_x   = CW'(px);
        r.point_y   = CW'(py);
        r.pivot_x   = CW'(cx);
        r.pivot_y   = CW'(cy);
        r.angle_deg = ANGLE_W'(ang);
        return r;
    endfunction

    // Hold the point on s_axis until the transfer, then note it.
    task automatic send_point(point_req_t r);
        int gap;
        logic [S_W-1:0] data;
        gap = draw_wait(sender_burst);
        data = '0;
        data[4*CW+ANGLE_W-1:0] = {r.angle_deg, r.pivot_y, r.pivot_x, r.point_y, r.point_x};
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_point(r);
        if ($urandom_range(0, 39) == 0) sender_burst = ~sender_burst;
    endtask

    task automatic send_random_point();
        point_req_t r;
        int kind;
        int span;
        int ang;
        kind = $urandom_range(0, 9);
        r.pivot_x = CW'($urandom);
        r.pivot_y = CW'($urandom);
        span = 1 << $urandom_range(0, 16);
        case (kind)
            0: begin
                // point on the pivot
                r.point_x = r.pivot_x;
                r.point_y = r.pivot_y;
            end
            6, 7: begin
                r.point_x = CW'($urandom);
                r.point_y = CW'($urandom);
            end
            default: begin
                // point near the pivot, wraps freely at the range edges
                r.point_x = r.pivot_x + CW'(int'($urandom_range(0, 2*span)) - span);
                r.point_y = r.pivot_y + CW'(int'($urandom_range(0, 2*span)) - span);
            end
        endcase
        case ($urandom_range(0, 9))
            0:       ang = int'($urandom);
            1:       ang = (int'($urandom_range(0, 8)) - 4) * QUARTER_TURN_Q8
                           + int'($urandom_range(0, 2)) - 1;
            default: ang = int'($urandom_range(0, 2*FULL_TURN_Q8)) - FULL_TURN_Q8;
        endcase
        r.angle_deg = ANGLE_W'(ang);
        send_point(r);
    endtask

    // Result side: stall at random, check every transfer.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_wait(receiver_burst);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            sb.check_rotated(m_axis_tdata);
            if ($urandom_range(0, 39) == 0) receiver_burst = ~receiver_burst;
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL rotate_point_about_pivot_unit");
                $finish;
            end
        end
    end

    initial begin
        localparam int MAXC = (1 << (CW-1)) - 1;
        localparam int MINC = -(1 << (CW-1));
        localparam int ONE  = DEG_Q8_ONE;
        point_req_t directed[$];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // point on the pivot, at zero and at the range extremes
        directed.push_back(make_point(0, 0, 0, 0, 0));
        directed.push_back(make_point(MAXC, MINC, MAXC, MINC, 12345));
        // quarter, half and full turns, both signs, and an eighth turn
        directed.push_back(make_point(10*ONE, 0, 0, 0, 90*ONE));
        directed.push_back(make_point(10*ONE, 0, 0, 0, -90*ONE));
        directed.push_back(make_point(10*ONE, 3*ONE, 0, 0, HALF_TURN_Q8));
        directed.push_back(make_point(10*ONE, 3*ONE, 0, 0, -HALF_TURN_Q8));
        directed.push_back(make_point(-7*ONE, 5*ONE, ONE, ONE, FULL_TURN_Q8));
        directed.push_back(make_point(-7*ONE, 5*ONE, ONE, ONE, -FULL_TURN_Q8));
        directed.push_back(make_point(100*ONE, 0, 0, 0, 45*ONE));
        // fold past a quarter turn
        directed.push_back(make_point(50*ONE, 20*ONE, -3*ONE, 4*ONE, 270*ONE));
        directed.push_back(make_point(50*ONE, 20*ONE, -3*ONE, 4*ONE, -270*ONE));
        // angles beyond a full turn, down to the ends of the 18-bit field
        directed.push_back(make_point(1000, -2000, 30, 40, (1 << (ANGLE_W-1)) - 1));
        directed.push_back(make_point(1000, -2000, 30, 40, -(1 << (ANGLE_W-1))));
        // results that clamp at both ends
        directed.push_back(make_point(MAXC, 0, MINC, 0, HALF_TURN_Q8));
        directed.push_back(make_point(MINC, 0, MAXC, 0, HALF_TURN_Q8));
        directed.push_back(make_point(0, MAXC, 0, MINC, 0));
        directed.push_back(make_point(MAXC, MAXC, MINC, MINC, 45*ONE));
        directed.push_back(make_point(MINC, MINC, MAXC, MAXC, -135*ONE));
        directed.push_back(make_point(0, MINC, 0, MAXC, 90*ONE));
        // single-LSB offsets and angles
        directed.push_back(make_point(1, 0, 0, 0, 30*ONE));
        directed.push_back(make_point(500, -1, 500, 0, 90*ONE));
        directed.push_back(make_point(20*ONE, 20*ONE, 0, 0, 1));
        directed.push_back(make_point(20*ONE, 20*ONE, 0, 0, -1));

        foreach (directed[i]) send_point(directed[i]);
        directed_points = directed.size();

        repeat (RANDOM_POINTS) send_random_point();
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d points (%0d directed, %0d on the pivot); %0d results checked.",
                 sb.points_noted, directed_points, sb.pivot_hits, sb.results_checked);
        $display("Angles spanned the whole 18-bit field; coordinates reached both clamps.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS rotate_point_about_pivot_unit");
        end else begin
            $display("FAIL rotate_point_about_pivot_unit");
        end
        $finish;
    end

endmodule

FILE: rotate_point_about_pivot_unit.f
hdl/rpp_pkg.sv
hdl/rpp_prep.sv
hdl/rpp_cordic_stage.sv
hdl/rpp_post.sv
hdl/rotate_point_about_pivot_unit.sv
tb/tb_rotate_point_about_pivot_unit.sv
